[sv/nrp_pkg.sv]
// Package with the format table and character codes of the NMEA RMC sentence parser.
`default_nettype none

package nrp_pkg;

  localparam int unsigned FmtLen = 54;
  localparam int unsigned PosW   = 6;

  localparam logic [8*FmtLen-1:0] FmtRom =
    "$GPRMC,dddtdd.ds,A,eeae.eeee,l,eeeae.eeee,o,jdk,c,dddy";

  localparam logic [7:0] SymComma = 8'h2C;
  localparam logic [7:0] SymDigit = 8'h64;
  localparam logic [7:0] SymJump  = 8'h6A;
  localparam logic [7:0] SymLong  = 8'h65;
  localparam logic [7:0] SymSixty = 8'h61;
  localparam logic [7:0] SymTime  = 8'h74;
  localparam logic [7:0] SymSecs  = 8'h73;
  localparam logic [7:0] SymLat   = 8'h6C;
  localparam logic [7:0] SymLon   = 8'h6F;
  localparam logic [7:0] SymKnots = 8'h6B;
  localparam logic [7:0] SymCourse = 8'h63;
  localparam logic [7:0] SymDate  = 8'h79;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChNorth  = 8'h4E;
  localparam logic [7:0] ChEast   = 8'h45;
  localparam logic [7:0] ChZero   = 8'h30;

  // Entries past the end of the sentence template read as zero.
  function automatic logic [7:0] fmt_sym(input logic [PosW-1:0] pos);
    logic [7:0] sym;
    sym = 8'h00;
    if (int'(pos) < FmtLen) begin
      sym = FmtRom[8*(FmtLen-1-int'(pos)) +: 8];
    end
    return sym;
  endfunction

endpackage

`default_nettype wire

[sv/nmea_rmc_sentence_parser.sv]
// Top level of the NMEA RMC sentence parser: input register, parse step and published fields.
`default_nettype none

// Takes one character per beat and returns one result beat per character carrying the
// published fix fields after that character. A character can be accepted in every
// cycle while the output is not stalled. A character is taken into the input register
// at the accepting edge, and the parse step then loads the template position,
// accumulators and fields into the result register, from which its result beat is offered.
// The rate is set by the single parse step per cycle, which reads the 54-entry format
// table and does one multiply-by-ten or multiply-by-six and add. Stalls on the output
// side hold the result and back up into the input register.
module nmea_rmc_sentence_parser import nrp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         char_code_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [15:0]             fix_time_o,
  output logic [15:0]             fix_centisecs_o,
  output logic signed [31:0]      latitude_o,
  output logic signed [31:0]      longitude_o,
  output logic [15:0]             speed_knots_o,
  output logic [15:0]             course_value_o,
  output logic [15:0]             fix_date_o,
  output logic                    fix_valid_o
);

  logic            s1_valid_q;
  logic [7:0]      s1_char_q;
  logic            out_valid_q;
  logic            s2_load;
  logic            s1_load;

  logic [PosW-1:0] pos_q, pos_d, pos_base, pos_inc;
  logic [15:0]     sacc_q, sacc_d, sacc_base;
  logic [31:0]     lacc_q, lacc_d, lacc_base;
  logic [15:0]     time_q, time_d;
  logic [15:0]     csec_q, csec_d;
  logic [31:0]     lat_q, lat_d;
  logic [31:0]     lon_q, lon_d;
  logic [15:0]     knots_q, knots_d;
  logic [15:0]     course_q, course_d;
  logic [15:0]     date_q, date_d;
  logic            fix_flag_q, fix_flag_d;

  logic [7:0]      ch;
  logic [7:0]      sym;
  logic [15:0]     digit;
  logic [15:0]     short_push;
  logic [31:0]     long_ten;
  logic [31:0]     long_six;

  assign s2_load    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign s1_load    = in_valid_i && !in_stall_o;
  assign in_stall_o = s1_valid_q && !s2_load;

  always_comb begin
    ch         = s1_char_q;
    digit      = {8'h00, ch} - {8'h00, ChZero};
    pos_base   = (ch == ChDollar) ? '0 : pos_q;
    sacc_base  = (ch == ChDollar) ? '0 : sacc_q;
    lacc_base  = (ch == ChDollar) ? '0 : lacc_q;
    sym        = fmt_sym(pos_base);
    pos_inc    = pos_base + PosW'(1);
    short_push = {sacc_base[12:0], 3'b000} + {sacc_base[14:0], 1'b0} + digit;
    long_ten   = {lacc_base[28:0], 3'b000} + {lacc_base[30:0], 1'b0} + {16'h0000, digit};
    long_six   = {lacc_base[29:0], 2'b00} + {lacc_base[30:0], 1'b0} + {16'h0000, digit};

    pos_d      = pos_inc;
    sacc_d     = sacc_base;
    lacc_d     = lacc_base;
    time_d     = time_q;
    csec_d     = csec_q;
    lat_d      = lat_q;
    lon_d      = lon_q;
    knots_d    = knots_q;
    course_d   = course_q;
    date_d     = date_q;
    fix_flag_d = fix_flag_q;

    if (sym != ch) begin
      case (sym)
        SymComma: pos_d = pos_base;
        SymDigit: sacc_d = short_push;
        SymJump: begin
          if (ch != ChDot) begin
            sacc_d = short_push;
            pos_d  = pos_base;
          end
        end
        SymLong:  lacc_d = long_ten;
        SymSixty: lacc_d = long_six;
        SymTime: begin
          time_d = short_push;
          sacc_d = '0;
        end
        SymSecs: begin
          csec_d = short_push;
          sacc_d = '0;
        end
        SymLat: begin
          lat_d  = (ch == ChNorth) ? lacc_base : 32'd0 - lacc_base;
          lacc_d = '0;
        end
        SymLon: begin
          lon_d  = (ch == ChEast) ? lacc_base : 32'd0 - lacc_base;
          lacc_d = '0;
        end
        SymKnots: begin
          knots_d = short_push;
          sacc_d  = '0;
        end
        SymCourse: begin
          if (ch == SymComma) begin
            course_d = sacc_base;
            sacc_d   = '0;
            pos_d    = pos_inc + PosW'(1);
          end else if (ch == ChDot) begin
            pos_d = pos_base;
          end else begin
            sacc_d = short_push;
            pos_d  = pos_base;
          end
        end
        SymDate: begin
          date_d     = short_push;
          fix_flag_d = 1'b1;
          pos_d      = '0;
        end
        default: pos_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_char_q  <= '0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= 1'b1;
        s1_char_q  <= char_code_i;
      end else if (s2_load) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      sacc_q      <= '0;
      lacc_q      <= '0;
      time_q      <= '0;
      csec_q      <= '0;
      lat_q       <= '0;
      lon_q       <= '0;
      knots_q     <= '0;
      course_q    <= '0;
      date_q      <= '0;
      fix_flag_q  <= 1'b0;
    end else begin
      if (s2_load) begin
        out_valid_q <= 1'b1;
        pos_q       <= pos_d;
        sacc_q      <= sacc_d;
        lacc_q      <= lacc_d;
        time_q      <= time_d;
        csec_q      <= csec_d;
        lat_q       <= lat_d;
        lon_q       <= lon_d;
        knots_q     <= knots_d;
        course_q    <= course_d;
        date_q      <= date_d;
        fix_flag_q  <= fix_flag_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign fix_time_o      = time_q;
  assign fix_centisecs_o = csec_q;
  assign latitude_o      = lat_q;
  assign longitude_o     = lon_q;
  assign speed_knots_o   = knots_q;
  assign course_value_o  = course_q;
  assign fix_date_o      = date_q;
  assign fix_valid_o     = fix_flag_q;

  // The fix flag is sticky.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fix_flag_q |=> fix_flag_q)
    else $error("fix flag cleared");

  // Parser state moves only when a character is processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |=> $stable(pos_q) && $stable(sacc_q) && $stable(lacc_q))
    else $error("parser state changed without a character");

  // An accepted character is held in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> s1_valid_q && s1_char_q == $past(char_code_i))
    else $error("accepted character lost");

  // A processed character always produces a result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni) s2_load |=> out_valid_q)
    else $error("result beat missing");

endmodule

`default_nettype wire
